### hdl/hcbd_pkg.sv
package hcbd_pkg;

  localparam int SIZE_BITS_DEF  = 32;
  localparam int COUNT_BITS_DEF = 16;
  localparam int BYTE_W         = 8;
  localparam int LEN_W          = 16;
  localparam int CFG_W          = 16;
  localparam int DIGIT_W        = 4;

  localparam logic [CFG_W-1:0] MAX_OUT_RESET = CFG_W'(4095);

  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_LOW_X = 8'h78;
  localparam logic [BYTE_W-1:0] CH_UP_X  = 8'h58;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;

  typedef enum logic [5:0] {
    PH_LEAD   = 6'b000001,
    PH_NUM    = 6'b000010,
    PH_REST   = 6'b000100,
    PH_DATA   = 6'b001000,
    PH_TRAIL1 = 6'b010000,
    PH_TRAIL2 = 6'b100000
  } phase_t;

  typedef enum logic [2:0] {
    PFX_FRESH    = 3'b001,
    PFX_ONE_ZERO = 3'b010,
    PFX_CLOSED   = 3'b100
  } prefix_t;

  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              body_end;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              has_byte;
    logic              finished;
    logic [LEN_W-1:0]  decoded_length;
  } out_item_t;

  typedef struct packed {
    logic               valid;
    logic [DIGIT_W-1:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [BYTE_W-1:0] c);
    hex_digit_t h;
    h.valid = 1'b1;
    h.value = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = DIGIT_W'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.value = DIGIT_W'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.value = DIGIT_W'(c - 8'h37);
    end else begin
      h.valid = 1'b0;
    end
    return h;
  endfunction

endpackage

### hdl/http_chunked_body_decoder_top.sv
// A result is registered in out_data, or in the skid entry while the output is stalled.
// The parser takes one input byte per cycle while in_ready is high; the per-byte parser
// update is a single registered step, and a two-entry output buffer holds one more
// result while the output is stalled before in_ready drops.
// Reset (rst_n low, synchronous): parser state cleared, output buffer emptied,
// max_output_bytes back to 4095. No clearing pass is needed.
module http_chunked_body_decoder_top #(
  parameter int SIZE_BITS  = hcbd_pkg::SIZE_BITS_DEF,
  parameter int COUNT_BITS = hcbd_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  hcbd_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output hcbd_pkg::out_item_t             out_data,
  input  logic                            cfg_wr_en,
  input  logic [hcbd_pkg::CFG_W-1:0]      cfg_wr_data
);

  localparam int CW = (COUNT_BITS > hcbd_pkg::CFG_W) ? COUNT_BITS : hcbd_pkg::CFG_W;
  localparam logic [CW-1:0] COUNT_MAX = CW'((64'd1 << COUNT_BITS) - 64'd1);
  localparam logic [SIZE_BITS-1:0] SIZE_MAX = '1;

  hcbd_pkg::phase_t               phase_r, phase_nxt;
  hcbd_pkg::prefix_t              prefix_r, prefix_nxt;
  logic [SIZE_BITS-1:0]           size_accum_r, size_accum_nxt;
  logic [SIZE_BITS-1:0]           data_left_r, data_left_nxt;
  logic [COUNT_BITS-1:0]          out_count_r, out_count_nxt;
  logic                           size_neg_r, size_neg_nxt;
  logic                           digit_seen_r, digit_seen_nxt;
  logic                           pending_cr_r, pending_cr_nxt;
  logic                           stopped_r, stopped_nxt;
  logic [hcbd_pkg::CFG_W-1:0]     max_out_r;

  hcbd_pkg::out_item_t            out_data_r, skid_r, res;
  logic                           out_valid_r, skid_valid_r;

  logic                           accept, res_valid, emit, do_num, do_rest, cap_stop;
  logic [CW-1:0]                  cap, count_ext, len_ext;
  hcbd_pkg::hex_digit_t           hex;
  logic [SIZE_BITS+hcbd_pkg::DIGIT_W-1:0] shifted;
  logic [hcbd_pkg::BYTE_W-1:0]    c;

  assign in_ready  = !skid_valid_r;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    c         = in_data.in_byte;
    hex       = hcbd_pkg::hex_decode(c);
    shifted   = {size_accum_r, hex.value};
    cap       = (CW'(max_out_r) < COUNT_MAX) ? CW'(max_out_r) : COUNT_MAX;
    count_ext = CW'(out_count_r);
    cap_stop  = stopped_r || (count_ext >= cap);

    phase_nxt      = phase_r;
    prefix_nxt     = prefix_r;
    size_accum_nxt = size_accum_r;
    data_left_nxt  = data_left_r;
    out_count_nxt  = out_count_r;
    size_neg_nxt   = size_neg_r;
    digit_seen_nxt = digit_seen_r;
    pending_cr_nxt = pending_cr_r;
    stopped_nxt    = cap_stop;
    emit           = 1'b0;
    do_num         = 1'b0;
    do_rest        = 1'b0;

    if (!cap_stop) begin
      unique case (phase_r)
        hcbd_pkg::PH_LEAD: begin
          if (c == hcbd_pkg::CH_SPACE || c == hcbd_pkg::CH_TAB) begin
            phase_nxt = hcbd_pkg::PH_LEAD;
          end else if (c == hcbd_pkg::CH_PLUS || c == hcbd_pkg::CH_MINUS) begin
            size_neg_nxt = (c == hcbd_pkg::CH_MINUS);
            phase_nxt    = hcbd_pkg::PH_NUM;
          end else begin
            phase_nxt = hcbd_pkg::PH_NUM;
            do_num    = 1'b1;
          end
        end
        hcbd_pkg::PH_NUM: begin
          do_num = 1'b1;
        end
        hcbd_pkg::PH_REST: begin
          do_rest = 1'b1;
        end
        hcbd_pkg::PH_DATA: begin
          emit          = 1'b1;
          out_count_nxt = out_count_r + 1'b1;
          data_left_nxt = data_left_r - 1'b1;
          if (data_left_r == SIZE_BITS'(1)) begin
            phase_nxt = hcbd_pkg::PH_TRAIL1;
          end
        end
        hcbd_pkg::PH_TRAIL1: begin
          phase_nxt = hcbd_pkg::PH_TRAIL2;
        end
        hcbd_pkg::PH_TRAIL2: begin
          phase_nxt      = hcbd_pkg::PH_LEAD;
          size_accum_nxt = '0;
          size_neg_nxt   = 1'b0;
          digit_seen_nxt = 1'b0;
          prefix_nxt     = hcbd_pkg::PFX_FRESH;
          pending_cr_nxt = 1'b0;
        end
        default: begin
          phase_nxt = hcbd_pkg::PH_LEAD;
        end
      endcase
    end

    if (do_num) begin
      if (hex.valid) begin
        // A carry out of the top nibble means the size no longer fits.
        if (|shifted[SIZE_BITS+hcbd_pkg::DIGIT_W-1:SIZE_BITS]) begin
          size_accum_nxt = SIZE_MAX;
        end else begin
          size_accum_nxt = shifted[SIZE_BITS-1:0];
        end
        if (prefix_r == hcbd_pkg::PFX_FRESH && hex.value == '0) begin
          prefix_nxt = hcbd_pkg::PFX_ONE_ZERO;
        end else begin
          prefix_nxt = hcbd_pkg::PFX_CLOSED;
        end
        digit_seen_nxt = 1'b1;
      end else if ((c == hcbd_pkg::CH_LOW_X || c == hcbd_pkg::CH_UP_X) &&
                   prefix_r == hcbd_pkg::PFX_ONE_ZERO) begin
        prefix_nxt = hcbd_pkg::PFX_CLOSED;
      end else begin
        phase_nxt = hcbd_pkg::PH_REST;
        do_rest   = 1'b1;
      end
    end

    if (do_rest) begin
      if (c == hcbd_pkg::CH_LF && pending_cr_r) begin
        if (!digit_seen_r || size_neg_r || size_accum_r == '0) begin
          stopped_nxt = 1'b1;
        end else begin
          data_left_nxt = size_accum_r;
          phase_nxt     = hcbd_pkg::PH_DATA;
        end
        size_accum_nxt = '0;
        size_neg_nxt   = 1'b0;
        digit_seen_nxt = 1'b0;
        prefix_nxt     = hcbd_pkg::PFX_FRESH;
        pending_cr_nxt = 1'b0;
      end else begin
        pending_cr_nxt = (c == hcbd_pkg::CH_CR);
      end
    end

    len_ext            = CW'(out_count_nxt);
    res.out_byte       = emit ? c : '0;
    res.has_byte       = emit;
    res.finished       = in_data.body_end;
    res.decoded_length = len_ext[hcbd_pkg::LEN_W-1:0];
    res_valid          = accept && (emit || in_data.body_end);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= hcbd_pkg::PH_LEAD;
      prefix_r     <= hcbd_pkg::PFX_FRESH;
      size_accum_r <= '0;
      data_left_r  <= '0;
      out_count_r  <= '0;
      size_neg_r   <= 1'b0;
      digit_seen_r <= 1'b0;
      pending_cr_r <= 1'b0;
      stopped_r    <= 1'b0;
    end else if (accept) begin
      if (in_data.body_end) begin
        phase_r      <= hcbd_pkg::PH_LEAD;
        prefix_r     <= hcbd_pkg::PFX_FRESH;
        size_accum_r <= '0;
        data_left_r  <= '0;
        out_count_r  <= '0;
        size_neg_r   <= 1'b0;
        digit_seen_r <= 1'b0;
        pending_cr_r <= 1'b0;
        stopped_r    <= 1'b0;
      end else begin
        phase_r      <= phase_nxt;
        prefix_r     <= prefix_nxt;
        size_accum_r <= size_accum_nxt;
        data_left_r  <= data_left_nxt;
        out_count_r  <= out_count_nxt;
        size_neg_r   <= size_neg_nxt;
        digit_seen_r <= digit_seen_nxt;
        pending_cr_r <= pending_cr_nxt;
        stopped_r    <= stopped_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_out_r <= hcbd_pkg::MAX_OUT_RESET;
    end else if (cfg_wr_en) begin
      max_out_r <= cfg_wr_data;
    end
  end

  // The skid entry catches a result produced while the output register is stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_data_r <= skid_r;
      end else begin
        out_data_r <= res;
      end
    end else if (res_valid) begin
      skid_r <= res;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds a result while the output register is empty");

  a_no_byte_when_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && stopped_r) |-> !res.has_byte)
    else $error("payload byte produced after decoding stopped");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.body_end) |=> (phase_r == hcbd_pkg::PH_LEAD &&
                                       out_count_r == '0 && !stopped_r))
    else $error("parser state not cleared after body end transfer");

  a_data_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == hcbd_pkg::PH_DATA) |-> (data_left_r != '0))
    else $error("data phase entered with no bytes left");

endmodule

### sim/http_chunked_body_decoder_top_test.sv
module http_chunked_body_decoder_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned SIZE_SAT = 64'hFFFF_FFFF;

  logic                         clk;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  hcbd_pkg::in_item_t           in_data = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  hcbd_pkg::out_item_t          out_data;
  logic                         cfg_wr_en = 1'b0;
  logic [hcbd_pkg::CFG_W-1:0]   cfg_wr_data = '0;

  http_chunked_body_decoder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Decoder state mirrored by the testbench.
  logic [hcbd_pkg::CFG_W-1:0]  cap_reg;
  hcbd_pkg::phase_t            dec_phase;
  longint unsigned             size_acc;
  longint unsigned             chunk_left;
  logic [hcbd_pkg::LEN_W-1:0]  out_count;
  logic                        size_neg;
  logic                        digit_seen;
  hcbd_pkg::prefix_t           pfx;
  logic                        cr_seen;
  logic                        halted;

  hcbd_pkg::out_item_t decoded_fifo[$];
  logic [7:0]          body_q[$];
  int                  mismatches = 0;
  int                  bytes_sent = 0;
  int                  send_idle_pct = 0;
  int                  recv_stall_pct = 0;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic clear_line();
    size_acc = 0;
    size_neg = 1'b0;
    digit_seen = 1'b0;
    pfx = hcbd_pkg::PFX_FRESH;
    cr_seen = 1'b0;
  endtask

  task automatic clear_body();
    dec_phase = hcbd_pkg::PH_LEAD;
    chunk_left = 0;
    out_count = '0;
    halted = 1'b0;
    clear_line();
  endtask

  // Text after the size digits: only CR immediately followed by LF ends the line.
  task automatic line_tail(input logic [7:0] c);
    if (c == hcbd_pkg::CH_LF && cr_seen) begin
      if (!digit_seen || size_neg || size_acc == 0) begin
        halted = 1'b1;
      end else begin
        chunk_left = size_acc;
        dec_phase = hcbd_pkg::PH_DATA;
      end
      clear_line();
    end else begin
      cr_seen = (c == hcbd_pkg::CH_CR);
    end
  endtask

  task automatic size_digit(input logic [7:0] c);
    int d;
    longint unsigned du;
    if (c >= "0" && c <= "9") begin
      d = c - "0";
    end else if (c >= "a" && c <= "f") begin
      d = c - "a" + 10;
    end else if (c >= "A" && c <= "F") begin
      d = c - "A" + 10;
    end else begin
      d = -1;
    end
    if (d >= 0) begin
      du = d;
      if (size_acc > (SIZE_SAT - du) / 16) begin
        size_acc = SIZE_SAT;
      end else begin
        size_acc = size_acc * 16 + du;
      end
      if (pfx == hcbd_pkg::PFX_FRESH && d == 0) begin
        pfx = hcbd_pkg::PFX_ONE_ZERO;
      end else begin
        pfx = hcbd_pkg::PFX_CLOSED;
      end
      digit_seen = 1'b1;
    end else if ((c == hcbd_pkg::CH_LOW_X || c == hcbd_pkg::CH_UP_X) &&
                 pfx == hcbd_pkg::PFX_ONE_ZERO) begin
      pfx = hcbd_pkg::PFX_CLOSED;
    end else begin
      dec_phase = hcbd_pkg::PH_REST;
      line_tail(c);
    end
  endtask

  task automatic decode_byte(input hcbd_pkg::in_item_t item);
    hcbd_pkg::out_item_t res;
    logic      emit;
    logic [7:0] c;
    res = '0;
    emit = 1'b0;
    c = item.in_byte;
    if (!halted && out_count >= cap_reg) begin
      halted = 1'b1;
    end
    if (!halted) begin
      case (dec_phase)
        hcbd_pkg::PH_LEAD: begin
          if (c == hcbd_pkg::CH_SPACE || c == hcbd_pkg::CH_TAB) begin
          end else if (c == hcbd_pkg::CH_PLUS || c == hcbd_pkg::CH_MINUS) begin
            size_neg = (c == hcbd_pkg::CH_MINUS);
            dec_phase = hcbd_pkg::PH_NUM;
          end else begin
            dec_phase = hcbd_pkg::PH_NUM;
            size_digit(c);
          end
        end
        hcbd_pkg::PH_NUM: size_digit(c);
        hcbd_pkg::PH_REST: line_tail(c);
        hcbd_pkg::PH_DATA: begin
          emit = 1'b1;
          res.out_byte = c;
          out_count++;
          chunk_left--;
          if (chunk_left == 0) begin
            dec_phase = hcbd_pkg::PH_TRAIL1;
          end
        end
        hcbd_pkg::PH_TRAIL1: dec_phase = hcbd_pkg::PH_TRAIL2;
        default: begin
          dec_phase = hcbd_pkg::PH_LEAD;
          clear_line();
        end
      endcase
    end
    if (emit || item.body_end) begin
      res.has_byte = emit;
      res.finished = item.body_end;
      res.decoded_length = out_count;
      decoded_fifo.push_back(res);
    end
    if (item.body_end) begin
      clear_body();
    end
  endtask

  always @(posedge clk) begin
    hcbd_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (decoded_fifo.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: byte=%02h has_byte=%0b finished=%0b length=%0d",
                 $time, out_data.out_byte, out_data.has_byte, out_data.finished,
                 out_data.decoded_length);
      end else begin
        want = decoded_fifo.pop_front();
        if (out_data.out_byte !== want.out_byte || out_data.has_byte !== want.has_byte ||
            out_data.finished !== want.finished ||
            out_data.decoded_length !== want.decoded_length) begin
          mismatches++;
          $display("%0t: result mismatch: expected byte=%02h has_byte=%0b finished=%0b length=%0d",
                   $time, want.out_byte, want.has_byte, want.finished, want.decoded_length);
          $display("%0t:                  actual byte=%02h has_byte=%0b finished=%0b length=%0d",
                   $time, out_data.out_byte, out_data.has_byte, out_data.finished,
                   out_data.decoded_length);
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    hcbd_pkg::in_item_t item;
    item.in_byte = b;
    item.body_end = last;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    decode_byte(item);
  endtask

  task automatic send_body(input bit with_end);
    foreach (body_q[i]) begin
      send_byte(body_q[i], with_end && i == body_q.size() - 1);
    end
    body_q.delete();
  endtask

  // Called at the edge of the last transfer, so valid drops without a repeated item.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (decoded_fifo.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [hcbd_pkg::CFG_W-1:0] value);
    wait_for_drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cap_reg = value;
  endtask

  task automatic push_text(input string s);
    foreach (s[i]) body_q.push_back(s[i]);
  endtask

  task automatic push_crlf();
    body_q.push_back(hcbd_pkg::CH_CR);
    body_q.push_back(hcbd_pkg::CH_LF);
  endtask

  task automatic push_random(input int n);
    repeat (n) body_q.push_back(8'($urandom_range(255)));
  endtask

  task automatic push_size_line(input int value);
    string digits;
    if ($urandom_range(2) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        body_q.push_back($urandom_range(1) ? hcbd_pkg::CH_SPACE : hcbd_pkg::CH_TAB);
      end
    end
    if ($urandom_range(7) == 0) begin
      body_q.push_back(hcbd_pkg::CH_PLUS);
    end
    if ($urandom_range(5) == 0) begin
      body_q.push_back("0");
      body_q.push_back($urandom_range(1) ? hcbd_pkg::CH_LOW_X : hcbd_pkg::CH_UP_X);
    end else if ($urandom_range(4) == 0) begin
      repeat ($urandom_range(1, 3)) body_q.push_back("0");
    end
    digits = $sformatf("%0h", value);
    foreach (digits[i]) begin
      body_q.push_back((digits[i] >= "a" && $urandom_range(1)) ? digits[i] - 8'h20 : digits[i]);
    end
    // A chunk extension, sometimes with a lone LF or a lone CR inside it.
    if ($urandom_range(4) == 0) begin
      push_text(";e");
      case ($urandom_range(2))
        0: body_q.push_back(hcbd_pkg::CH_LF);
        1: begin
          body_q.push_back(hcbd_pkg::CH_CR);
          push_text("=");
        end
        default: push_text("=v");
      endcase
    end
    push_crlf();
  endtask

  task automatic build_random_body();
    int len;
    if ($urandom_range(9) == 0) begin
      push_random($urandom_range(1, 12));
      return;
    end
    repeat ($urandom_range(0, 3)) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      push_size_line(len);
      push_random(len);
      if ($urandom_range(5) == 0) begin
        push_random(2);
      end else begin
        push_crlf();
      end
    end
    case ($urandom_range(9))
      0, 1, 2, 3, 4: begin
        push_text("0");
        if ($urandom_range(1)) begin
          push_text("0");
        end
        push_crlf();
        push_crlf();
      end
      5: begin
        push_text("-");
        push_text($sformatf("%0h", $urandom_range(1, 255)));
        push_crlf();
      end
      6: begin
        push_text("-0");
        push_crlf();
        push_random(1);
      end
      7: begin
        if ($urandom_range(1)) begin
          push_text(" ;q");
        end else begin
          push_text("zz");
        end
        push_crlf();
      end
      8: begin
        // Too many digits: the size saturates and the body ends inside the data.
        push_text("+0x");
        repeat ($urandom_range(9, 12)) body_q.push_back($urandom_range(1) ? "F" : "f");
        push_crlf();
        push_random($urandom_range(1, 6));
      end
      default: begin
      end
    endcase
    if ($urandom_range(7) == 0 && body_q.size() > 1) begin
      len = $urandom_range(1, body_q.size() - 1);
      while (body_q.size() > len) void'(body_q.pop_back());
    end
    if (body_q.size() == 0) begin
      push_random(1);
    end
  endtask

  task automatic test_size_line_forms();
    body_q.push_back(hcbd_pkg::CH_TAB);
    push_text(" 0X2");
    push_crlf();
    body_q.push_back(8'h00);
    body_q.push_back(8'hFF);
    push_crlf();
    push_text("-0");
    push_crlf();
    send_body(1);
    // Lone CR and lone LF inside the size line do not end it.
    push_text("1");
    body_q.push_back(hcbd_pkg::CH_CR);
    push_text("x");
    body_q.push_back(hcbd_pkg::CH_LF);
    push_crlf();
    push_text("A");
    send_body(1);
    push_text("f");
    send_body(1);
  endtask

  task automatic test_zero_capacity();
    write_capacity(16'd0);
    push_text("1");
    push_crlf();
    push_text("A");
    send_body(1);
  endtask

  task automatic test_capacity_lowered_midbody();
    write_capacity(hcbd_pkg::MAX_OUT_RESET);
    push_text("5");
    push_crlf();
    push_random(2);
    send_body(0);
    write_capacity(16'd1);
    push_random(1);
    send_body(1);
  endtask

  task automatic test_random_bodies(input int idle_in, input int stall_out,
                                    input int cap_lo, input int cap_hi, input int n_bytes);
    int start;
    send_idle_pct = idle_in;
    recv_stall_pct = stall_out;
    start = bytes_sent;
    write_capacity(hcbd_pkg::CFG_W'($urandom_range(cap_lo, cap_hi)));
    while (bytes_sent - start < n_bytes) begin
      if ($urandom_range(3) == 0) begin
        write_capacity(hcbd_pkg::CFG_W'($urandom_range(cap_lo, cap_hi)));
      end
      build_random_body();
      send_body(1);
    end
  endtask

  initial begin
    cap_reg = hcbd_pkg::MAX_OUT_RESET;
    clear_body();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_size_line_forms();
    test_zero_capacity();
    test_capacity_lowered_midbody();
    test_random_bodies(0, 0, 65535, 65535, 140);
    test_random_bodies(76, 0, 2, 40, 140);
    test_random_bodies(0, 76, 40, 4095, 140);
    test_random_bodies(8, 8, 0, 12, 140);
    wait_for_drain();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && decoded_fifo.size() == 0) begin
      $display("http_chunked_body_decoder_top regression: pass");
    end else begin
      $display("http_chunked_body_decoder_top regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("http_chunked_body_decoder_top regression: fail");
    $finish;
  end

endmodule

### filelist.f
hdl/hcbd_pkg.sv
hdl/http_chunked_body_decoder_top.sv
sim/http_chunked_body_decoder_top_test.sv
